FILE: rtl/core/crsf_pkg.sv
// Shared types and constants of the serial link frame builder.
package crsf_pkg;

	// Input item kinds.
	localparam logic KIND_START = 1'b0;
	localparam logic KIND_DATA  = 1'b1;

	// Configuration register indexes.
	localparam int unsigned CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_BYTE = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_CRC_POLY  = 1'd1;

	// Register reset values.
	localparam logic [7:0] SYNC_BYTE_RESET = 8'd200;
	localparam logic [7:0] CRC_POLY_RESET  = 8'hD5;

	// Default depth of the command queue between front and back.
	localparam int unsigned CRSF_QUEUE_DEPTH = 4;

	// One classified command, as passed from the front to the back.
	typedef struct packed {
		logic       is_start;
		logic       last;
		logic       ext;
		logic [7:0] plen;
		logic [7:0] ftype;
		logic [7:0] dst;
		logic [7:0] src;
		logic [7:0] dbyte;
	} cmd_t;

endpackage

FILE: rtl/core/crsf_frame_builder_crc8.sv
// Top level of the serial link frame builder with CRC-8 trailer.
//
//   Channel   Direction  Handshake             Payload
//   input     in         in_valid / in_stall   kind, payload_len, frame_type, extended,
//                                              dest_addr, src_addr, data_byte
//   output    out        out_valid / out_stall out_byte, run_last, frame_end
//   config    in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// The back-end sequencer issues output bytes one at a time, which is what sets the rate:
// a payload item yields its byte, followed by the CRC when it carries the last byte;
// a start item yields sync, length and type bytes, then optional dest and src and an
// optional CRC for an empty frame. The input side accepts one item per cycle while the
// command queue has room, so a start is absorbed whilst earlier bytes are still going out.
// Reset (arst_n low) empties the queue, closes any frame and loads the register defaults.
// An output stall holds the registered byte; the queue fills behind it and then stalls input.
module crsf_frame_builder_crc8
	import crsf_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = CRSF_QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Input item channel.
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   kind,
	input  logic [7:0]             payload_len,
	input  logic [7:0]             frame_type,
	input  logic                   extended,
	input  logic [7:0]             dest_addr,
	input  logic [7:0]             src_addr,
	input  logic [7:0]             data_byte,
	// Output byte channel.
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [7:0]             out_byte,
	output logic                   run_last,
	output logic                   frame_end,
	// Configuration write channel.
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]             cfg_data
);

	logic [7:0] sync_byte_q;
	logic [7:0] crc_poly_q;

	logic q_full;
	logic q_push;
	cmd_t q_cmd;
	logic q_pop;
	logic head_valid;
	cmd_t head_cmd;

	// Register writes are always taken; software must write only whilst the block is idle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_byte_q <= SYNC_BYTE_RESET;
			crc_poly_q  <= CRC_POLY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SYNC_BYTE: sync_byte_q <= cfg_data;
				CFG_CRC_POLY:  crc_poly_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// The front end keeps the frame bookkeeping, so it can drop stray payload bytes and
	// mark the final payload byte of each frame before the command is queued.
	crsf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.payload_len (payload_len),
		.frame_type  (frame_type),
		.extended    (extended),
		.dest_addr   (dest_addr),
		.src_addr    (src_addr),
		.data_byte   (data_byte),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_cmd       (q_cmd)
	);

	crsf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (q_cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	// The back end turns each command into bytes, one per cycle unless stalled, and owns the CRC.
	crsf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.sync_byte  (sync_byte_q),
		.crc_poly   (crc_poly_q),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.run_last   (run_last),
		.frame_end  (frame_end)
	);

endmodule

FILE: rtl/core/crsf_front.sv
// Front end: accepts input items, tracks the open frame and classifies each item.
module crsf_front
	import crsf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       kind,
	input  logic [7:0] payload_len,
	input  logic [7:0] frame_type,
	input  logic       extended,
	input  logic [7:0] dest_addr,
	input  logic [7:0] src_addr,
	input  logic [7:0] data_byte,
	input  logic       q_full,
	output logic       q_push,
	output cmd_t       q_cmd
);

	logic       open_q;
	logic [7:0] left_q;
	logic       accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	// Payload bytes that arrive with no frame open are dropped here.
	assign q_push = accept && ((kind == KIND_START) || open_q);

	always_comb begin
		q_cmd.is_start = (kind == KIND_START);
		q_cmd.last     = (left_q == 8'd1);
		q_cmd.ext      = extended;
		q_cmd.plen     = payload_len;
		q_cmd.ftype    = frame_type;
		q_cmd.dst      = dest_addr;
		q_cmd.src      = src_addr;
		q_cmd.dbyte    = data_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			left_q <= 8'd0;
		end else if (accept) begin
			if (kind == KIND_START) begin
				open_q <= (payload_len != 8'd0);
				left_q <= payload_len;
			end else if (open_q) begin
				left_q <= left_q - 8'd1;
				if (left_q == 8'd1) begin
					open_q <= 1'b0;
				end
			end
		end
	end

endmodule

FILE: rtl/core/crsf_queue.sv
// Short command queue that decouples the front end from the byte sequencer.
module crsf_queue
	import crsf_pkg::*;
#(
	parameter int unsigned DEPTH = CRSF_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output cmd_t head_cmd
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

	cmd_t          entries_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = entries_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

FILE: rtl/core/crsf_back.sv
// Back end: steps through the bytes of each command, folds the CRC and drives the output.
module crsf_back
	import crsf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] sync_byte,
	input  logic [7:0] crc_poly,
	input  logic       head_valid,
	input  cmd_t       head_cmd,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       frame_end
);

	localparam logic [2:0] STEP_FIRST = 3'd0;
	localparam logic [2:0] STEP_LEN   = 3'd1;
	localparam logic [2:0] STEP_TYPE  = 3'd2;
	localparam logic [2:0] STEP_DST   = 3'd3;
	localparam logic [2:0] STEP_SRC   = 3'd4;
	localparam logic [2:0] STEP_CRC   = 3'd5;

	localparam logic [7:0] CRC_TOP_BIT = 8'h80;

	logic [2:0] step_q;
	logic [7:0] crc_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       run_last_q;
	logic       frame_end_q;

	logic       load;
	logic [2:0] step_nxt;
	logic [7:0] crc_nxt;
	logic [7:0] byte_nxt;
	logic       done;
	logic       is_crc;

	// One CRC-8 byte fold, MSB first, eight shift steps.
	function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b,
		input logic [7:0] poly);
		logic [7:0] v;
		v = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if ((v & CRC_TOP_BIT) != 8'd0) begin
				v = (v << 1) ^ poly;
			end else begin
				v = v << 1;
			end
		end
		return v;
	endfunction

	assign load = head_valid && (!out_valid_q || !out_stall);
	assign pop  = load && done;

	always_comb begin
		step_nxt = STEP_FIRST;
		crc_nxt  = crc_q;
		byte_nxt = head_cmd.dbyte;
		done     = 1'b0;
		is_crc   = 1'b0;
		unique case (step_q)
			STEP_FIRST: begin
				if (head_cmd.is_start) begin
					byte_nxt = sync_byte;
					step_nxt = STEP_LEN;
				end else begin
					byte_nxt = head_cmd.dbyte;
					crc_nxt  = crc_fold(crc_q, head_cmd.dbyte, crc_poly);
					done     = !head_cmd.last;
					step_nxt = head_cmd.last ? STEP_CRC : STEP_FIRST;
				end
			end
			STEP_LEN: begin
				byte_nxt = head_cmd.plen + (head_cmd.ext ? 8'd4 : 8'd2);
				step_nxt = STEP_TYPE;
			end
			STEP_TYPE: begin
				byte_nxt = head_cmd.ftype;
				crc_nxt  = crc_fold(8'd0, head_cmd.ftype, crc_poly);
				if (head_cmd.ext) begin
					step_nxt = STEP_DST;
				end else if (head_cmd.plen == 8'd0) begin
					step_nxt = STEP_CRC;
				end else begin
					done = 1'b1;
				end
			end
			STEP_DST: begin
				byte_nxt = head_cmd.dst;
				crc_nxt  = crc_fold(crc_q, head_cmd.dst, crc_poly);
				step_nxt = STEP_SRC;
			end
			STEP_SRC: begin
				byte_nxt = head_cmd.src;
				crc_nxt  = crc_fold(crc_q, head_cmd.src, crc_poly);
				if (head_cmd.plen == 8'd0) begin
					step_nxt = STEP_CRC;
				end else begin
					done = 1'b1;
				end
			end
			STEP_CRC: begin
				byte_nxt = crc_q;
				crc_nxt  = 8'd0;
				is_crc   = 1'b1;
				done     = 1'b1;
			end
			default: begin
				done = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= STEP_FIRST;
			crc_q       <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				step_q      <= done ? STEP_FIRST : step_nxt;
				crc_q       <= crc_nxt;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q  <= byte_nxt;
			run_last_q  <= done;
			frame_end_q <= is_crc;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_last  = run_last_q;
	assign frame_end = frame_end_q;

	// A CRC byte always closes the run of results of its item.
	a_crc_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && frame_end_q) |-> run_last_q)
		else $error("CRC byte delivered without run_last");

	// A command is never popped halfway: mid-sequence steps need a head.
	a_step_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q != STEP_FIRST) |-> head_valid)
		else $error("sequencer mid-command with an empty queue");

	// Address steps only occur for extended start commands.
	a_addr_step_ext: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == STEP_DST || step_q == STEP_SRC) |-> (head_cmd.is_start && head_cmd.ext))
		else $error("address step on a command that is not an extended start");

	// The running CRC is cleared once the CRC byte has been issued.
	a_crc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(load && step_q == STEP_CRC) |=> (crc_q == 8'd0))
		else $error("CRC accumulator not cleared after the CRC byte");

endmodule

FILE: bench/crsf_frame_builder_crc8_tb.sv
// Self-checking testbench of the serial link frame builder with CRC-8 trailer.
module crsf_frame_builder_crc8_tb
	import crsf_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	// Run-time bounds. The cycle limit is many times the slowest legal run of this stimulus.
	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 64;
	localparam int RANDOM_ITEMS  = 110;
	localparam int IDLE_PCT      = 26;

	// One input transaction, as seen on the input channel ports.
	typedef struct {
		logic       kind;
		logic [7:0] plen;
		logic [7:0] ftype;
		logic       ext;
		logic [7:0] dst;
		logic [7:0] src;
		logic [7:0] dbyte;
	} link_item_t;

	// One output transaction: a frame byte and its two flags.
	typedef struct {
		logic [7:0] value;
		logic       last;
		logic       is_crc;
	} frame_byte_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic                   kind;
	logic [7:0]             payload_len;
	logic [7:0]             frame_type;
	logic                   extended;
	logic [7:0]             dest_addr;
	logic [7:0]             src_addr;
	logic [7:0]             data_byte;
	logic                   out_valid;
	logic                   out_stall;
	logic [7:0]             out_byte;
	logic                   run_last;
	logic                   frame_end;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [7:0]             cfg_data;

	// Bytes the frame builder is expected to emit, oldest first.
	frame_byte_t expected_bytes[$];

	// The testbench's own copy of the registers and of the framing state.
	logic [7:0] mdl_sync;
	logic [7:0] mdl_poly;
	logic       tx_open;
	logic [7:0] tx_left;
	logic [7:0] tx_crc;

	// Percentage of cycles in which the sender pauses and the receiver stalls.
	int in_idle_pct;
	int out_idle_pct;
	int failures    = 0;
	int cycle_count = 0;

	crsf_frame_builder_crc8 DUT (.*);

	always #4 clk = ~clk;

	// Watchdog: a run that stops making progress ends here as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// One byte folded into the CRC, most significant bit first, with the current polynomial.
	function automatic logic [7:0] crc8_fold(logic [7:0] crc, logic [7:0] b);
		logic [7:0] v;
		v = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (v[7]) v = (v << 1) ^ mdl_poly;
			else      v = v << 1;
		end
		return v;
	endfunction

	// Works out the bytes caused by one accepted input transaction and queues them.
	// A start sends the header and, for an empty frame, the CRC straight away. A data
	// byte is passed on only while a frame is open, and the CRC follows the last one.
	function automatic void predict_bytes(link_item_t it);
		frame_byte_t run[$];
		logic [7:0]  len_byte;
		logic [7:0]  crc;
		if (it.kind == KIND_START) begin
			crc      = 8'h00;
			len_byte = it.plen + (it.ext ? 8'd4 : 8'd2);
			run.push_back('{mdl_sync, 1'b0, 1'b0});
			run.push_back('{len_byte, 1'b0, 1'b0});
			run.push_back('{it.ftype, 1'b0, 1'b0});
			crc = crc8_fold(crc, it.ftype);
			if (it.ext) begin
				run.push_back('{it.dst, 1'b0, 1'b0});
				crc = crc8_fold(crc, it.dst);
				run.push_back('{it.src, 1'b0, 1'b0});
				crc = crc8_fold(crc, it.src);
			end
			// An open frame is simply abandoned by the new start, with no CRC for it.
			if (it.plen == 8'd0) begin
				run.push_back('{crc, 1'b0, 1'b1});
				tx_open = 1'b0;
				tx_left = 8'd0;
				tx_crc  = 8'h00;
			end else begin
				tx_open = 1'b1;
				tx_left = it.plen;
				tx_crc  = crc;
			end
		end else if (tx_open) begin
			run.push_back('{it.dbyte, 1'b0, 1'b0});
			tx_crc  = crc8_fold(tx_crc, it.dbyte);
			tx_left = tx_left - 8'd1;
			if (tx_left == 8'd0) begin
				run.push_back('{tx_crc, 1'b0, 1'b1});
				tx_open = 1'b0;
				tx_crc  = 8'h00;
			end
		end
		if (run.size() != 0) run[run.size()-1].last = 1'b1;
		foreach (run[i]) expected_bytes.push_back(run[i]);
	endfunction

	// Half the time a random byte, otherwise one of the two extremes.
	function automatic logic [7:0] pick_byte();
		int roll;
		roll = $urandom_range(0, 3);
		if (roll == 0) return 8'h00;
		if (roll == 1) return 8'hFF;
		return 8'($urandom);
	endfunction

	// A start transaction; the data byte is noise that the block must ignore.
	function automatic link_item_t start_item(logic [7:0] plen, logic ext, logic [7:0] ftype,
			logic [7:0] dst, logic [7:0] src);
		link_item_t it;
		it.kind  = KIND_START;
		it.plen  = plen;
		it.ftype = ftype;
		it.ext   = ext;
		it.dst   = dst;
		it.src   = src;
		it.dbyte = 8'($urandom);
		return it;
	endfunction

	// A payload transaction; the header fields are noise that the block must ignore.
	function automatic link_item_t data_item(logic [7:0] b);
		link_item_t it;
		it.kind  = KIND_DATA;
		it.plen  = 8'($urandom_range(0, 251));
		it.ftype = 8'($urandom);
		it.ext   = 1'($urandom);
		it.dst   = 8'($urandom);
		it.src   = 8'($urandom);
		it.dbyte = b;
		return it;
	endfunction

	// Sends one input transaction, with an optional random pause before it. The task is
	// always entered just after a rising edge, and it returns at the edge of acceptance,
	// leaving in_valid high so that back-to-back transactions need no second assignment.
	task automatic send_item(link_item_t it);
		if ($urandom_range(0, 99) < in_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < in_idle_pct);
		end
		in_valid    <= 1'b1;
		kind        <= it.kind;
		payload_len <= it.plen;
		frame_type  <= it.ftype;
		extended    <= it.ext;
		dest_addr   <= it.dst;
		src_addr    <= it.src;
		data_byte   <= it.dbyte;
		do @(posedge clk); while (in_stall);
		predict_bytes(it);
	endtask

	// A well-formed frame: a start followed by exactly its payload bytes.
	task automatic run_frame(logic [7:0] plen, logic ext);
		send_item(start_item(plen, ext, 8'($urandom), pick_byte(), pick_byte()));
		repeat (plen) send_item(data_item(8'($urandom)));
	endtask

	// Lets every expected byte come out, then lets the block settle; dropped payload bytes
	// never enter its queue, so they cause no output to wait for.
	task automatic wait_for_idle();
		in_valid <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes both registers back to back once the block is idle.
	task automatic set_config(logic [7:0] sync, logic [7:0] poly);
		wait_for_idle();
		cfg_valid <= 1'b1;
		cfg_index <= CFG_SYNC_BYTE;
		cfg_data  <= sync;
		do @(posedge clk); while (!cfg_ready);
		mdl_sync = sync;
		cfg_index <= CFG_CRC_POLY;
		cfg_data  <= poly;
		do @(posedge clk); while (!cfg_ready);
		mdl_poly = poly;
		cfg_valid <= 1'b0;
	endtask

	// Header forms, empty frames, stray payload bytes and abandoned frames at reset values.
	task automatic test_header_cases();
		// Nothing is open straight after reset, so this byte is dropped.
		send_item(data_item(8'hA5));
		// Empty frames: the CRC follows the header in the same run of bytes.
		send_item(start_item(8'd0, 1'b0, 8'h00, 8'h5A, 8'hA5));
		send_item(start_item(8'd0, 1'b1, 8'hFF, 8'h00, 8'hFF));
		// Short frames with extreme payload bytes.
		send_item(start_item(8'd1, 1'b0, 8'h16, 8'h00, 8'h00));
		send_item(data_item(8'h00));
		send_item(start_item(8'd2, 1'b1, 8'h80, 8'hFF, 8'h00));
		send_item(data_item(8'hFF));
		send_item(data_item(8'h55));
		// The frame is complete, so a further byte is dropped.
		send_item(data_item(8'hFF));
		// Payloads of 251 bytes, plain and extended, each abandoned by the next start.
		send_item(start_item(8'd251, 1'b0, 8'hAA, 8'h00, 8'h00));
		send_item(data_item(8'h01));
		send_item(data_item(8'h02));
		send_item(start_item(8'd251, 1'b1, 8'h55, 8'hEA, 8'hEE));
		send_item(data_item(8'h12));
		send_item(start_item(8'd0, 1'b0, 8'h7F, 8'hFF, 8'hFF));
		send_item(data_item(8'h33));
	endtask

	// Sync byte and polynomial at their extremes, then back to the reset values.
	task automatic test_register_extremes();
		set_config(8'h00, 8'h00);
		run_frame(8'd3, 1'b0);
		run_frame(8'd0, 1'b1);
		set_config(8'hFF, 8'hFF);
		run_frame(8'd3, 1'b1);
		run_frame(8'd0, 1'b0);
		set_config(8'h5A, 8'h01);
		run_frame(8'd4, 1'b0);
		set_config(SYNC_BYTE_RESET, CRC_POLY_RESET);
	endtask

	// A polynomial change whilst a frame is open: later bytes fold with the new value.
	task automatic test_poly_mid_frame();
		send_item(start_item(8'd4, 1'b1, 8'($urandom), 8'($urandom), 8'($urandom)));
		send_item(data_item(8'($urandom)));
		send_item(data_item(8'($urandom)));
		set_config(mdl_sync, 8'h07);
		send_item(data_item(8'($urandom)));
		send_item(data_item(8'($urandom)));
		set_config(mdl_sync, CRC_POLY_RESET);
	endtask

	// One complete extended frame far longer than the random ones, so the payload count
	// runs down a long way before its CRC byte.
	task automatic test_long_frame();
		run_frame(8'd64, 1'b1);
	endtask

	// Mostly well-formed frames with random content and sizes, mixed with stray payload
	// bytes and frames cut short by a new start. The registers are rewritten every 60 items sent,
	// and the middle third runs with neither side pausing.
	task automatic test_random_traffic();
		int sent;
		int next_cfg;
		int roll;
		int len;
		int cut;
		sent     = 0;
		next_cfg = 60;
		while (sent < RANDOM_ITEMS) begin
			if (sent >= RANDOM_ITEMS / 3 && sent < 2 * RANDOM_ITEMS / 3) begin
				in_idle_pct  = 0;
				out_idle_pct = 0;
			end else begin
				in_idle_pct  = IDLE_PCT;
				out_idle_pct = IDLE_PCT;
			end
			if (sent >= next_cfg) begin
				set_config(pick_byte(), pick_byte());
				next_cfg += 60;
			end
			roll = $urandom_range(0, 99);
			if (roll < 8 && !tx_open) begin
				// Dropped by the block, so it does not count as traffic.
				send_item(data_item(8'($urandom)));
			end else if (roll < 20) begin
				len = $urandom_range(1, 251);
				cut = $urandom_range(0, (len > 6) ? 5 : len - 1);
				send_item(start_item(8'(len), 1'($urandom), 8'($urandom), pick_byte(),
					pick_byte()));
				repeat (cut) send_item(data_item(8'($urandom)));
				sent += 1 + cut;
			end else begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
				run_frame(8'(len), 1'($urandom));
				sent += 1 + len;
			end
		end
		in_idle_pct  = IDLE_PCT;
		out_idle_pct = IDLE_PCT;
	endtask

	// Output side: checks each accepted output transaction against the oldest expected
	// byte, then decides the stall for the next cycle. Values are read just after the
	// rising edge, before any register of the block or the testbench has moved.
	initial begin : check_output
		frame_byte_t want;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (expected_bytes.size() == 0) begin
					$error("unexpected output transaction: out_byte %02h", out_byte);
					failures++;
				end else begin
					want = expected_bytes.pop_front();
					if (out_byte !== want.value) begin
						$error("out_byte: expected %02h, got %02h", want.value, out_byte);
						failures++;
					end
					if (run_last !== want.last) begin
						$error("run_last: expected %0b, got %0b", want.last, run_last);
						failures++;
					end
					if (frame_end !== want.is_crc) begin
						$error("frame_end: expected %0b, got %0b", want.is_crc, frame_end);
						failures++;
					end
				end
			end
			out_stall <= ($urandom_range(0, 99) < out_idle_pct);
		end
	end

	// Main sequence: reset once, then each test in turn, then drain and report.
	initial begin
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		kind        <= KIND_START;
		payload_len <= 8'd0;
		frame_type  <= 8'd0;
		extended    <= 1'b0;
		dest_addr   <= 8'd0;
		src_addr    <= 8'd0;
		data_byte   <= 8'd0;
		cfg_valid   <= 1'b0;
		cfg_index   <= CFG_SYNC_BYTE;
		cfg_data    <= 8'd0;
		mdl_sync     = SYNC_BYTE_RESET;
		mdl_poly     = CRC_POLY_RESET;
		tx_open      = 1'b0;
		tx_left      = 8'd0;
		tx_crc       = 8'h00;
		in_idle_pct  = IDLE_PCT;
		out_idle_pct = IDLE_PCT;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_header_cases();
		test_register_extremes();
		test_poly_mid_frame();
		test_long_frame();
		test_random_traffic();

		wait_for_idle();
		if (failures == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
